// ===== src/blwc_pkg.sv =====
// shared types and constants for the bounded letter window counter
package blwc_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned OP_W     = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_PUSH    = 2'd2,
    OP_UNUSED  = 2'd3
  } blwc_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_LWR,
    ST_PRD,
    ST_PINC,
    ST_CHK,
    ST_EV1,
    ST_EV2,
    ST_EV3,
    ST_WR,
    ST_DONE
  } blwc_state_e;

endpackage

// ===== src/blwc_in_if.sv =====
// input channel: one command beat per item
interface blwc_in_if import blwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [LETTER_W-1:0] letter;
  logic [LIMIT_W-1:0]  limit_value;

  modport source (output valid, output opcode, output letter, output limit_value,
                  input ready);
  modport sink   (input valid, input opcode, input letter, input limit_value,
                  output ready);
endinterface

// ===== src/blwc_out_if.sv =====
// output channel: one result beat per item
interface blwc_out_if import blwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   window_length;
  logic [LEN_W-1:0]   substrings_ending_here;
  logic [TOTAL_W-1:0] running_total;
  logic               window_capped;

  modport source (output valid, output window_length, output substrings_ending_here,
                  output running_total, output window_capped, input ready);
  modport sink   (input valid, input window_length, input substrings_ending_here,
                  input running_total, input window_capped, output ready);
endinterface

// ===== src/blwc_tab.sv =====
// per-letter table with registered read, valid bits make unwritten entries read as zero
module blwc_tab #(
  parameter int unsigned DEPTH = 26,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // entry valid bits, cleared at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr_i] && !clr_i;
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/blwc_ram.sv =====
// letter ring buffer, one write and one registered read per cycle
module blwc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

// ===== src/bounded_letter_window_counter.sv =====
// Sliding window counter of letter substrings under per-letter limits.
// Items run through states: restart and ignored items go straight to ST_DONE, load passes
// ST_LRD and ST_LWR, push passes ST_PRD, ST_PINC, ST_CHK and ST_WR, without ST_WR when
// the letter is dropped; each letter evicted, for limits or one on a full buffer, adds
// ST_EV1, ST_EV2, ST_EV3. One item at a time, and a held result beat stalls the input.
// Reset is asynchronous active low; limits and counts read as zero after reset via valid bits.
module bounded_letter_window_counter import blwc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH  = 1024,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blwc_in_if.sink     in_i,
  blwc_out_if.source  out_o
);

  localparam int unsigned AW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned PtrW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned SizeW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 2);
  localparam int unsigned CmpW  = (CntW > LIMIT_W) ? CntW : LIMIT_W;
  localparam logic [PtrW:0]    DepthP  = (PtrW+1)'(WINDOW_DEPTH);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(WINDOW_DEPTH - 1);
  localparam logic [SizeW-1:0] FullSz  = SizeW'(WINDOW_DEPTH);

  blwc_state_e state_q, state_d;

  // item and window state
  blwc_op_e            op_q;
  logic [LETTER_W-1:0] let_q;
  logic [LIMIT_W-1:0]  lim_q;
  logic [PtrW-1:0]     oldest_q, oldest_d;
  logic [SizeW-1:0]    size_q, size_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [SizeW-1:0]    sub_q, sub_d;
  logic                cap_q, cap_d;
  logic                evcap_q, evcap_d;
  logic [AW-1:0]       old_q, old_d;
  logic                old_ok_q, old_ok_d;
  logic [ALPHABET_SIZE-1:0] over_q, over_d;

  // result register
  logic                out_vld_q;
  logic [LEN_W-1:0]    res_len_q, res_sub_q;
  logic [TOTAL_W-1:0]  res_total_q;
  logic                res_cap_q;

  // table and buffer ports
  logic                restart;
  logic                cnt_we, lim_we, ram_we;
  logic [AW-1:0]       cnt_waddr, tab_raddr;
  logic [CntW-1:0]     cnt_wdata, cnt_rd;
  logic [LIMIT_W-1:0]  lim_rd;
  logic [PtrW-1:0]     ram_waddr;
  logic [LETTER_W-1:0] ram_rd;

  logic                in_acc, out_load;
  logic [AW-1:0]       let_addr;
  logic [CntW-1:0]     cnt_inc, cnt_dec;
  logic [PtrW:0]       tail_sum;
  logic [PtrW-1:0]     tail;
  logic [TOTAL_W:0]    total_sum;
  logic [SizeW-1:0]    size_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  assign let_addr = AW'(let_q);
  assign cnt_inc  = cnt_rd + CntW'(1);
  assign cnt_dec  = cnt_rd - CntW'(1);
  assign size_inc = size_q + SizeW'(1);

  // tail slot, oldest plus size stays below twice the depth
  assign tail_sum = {1'b0, oldest_q} + (PtrW+1)'(size_q);
  assign tail     = (tail_sum >= DepthP) ? PtrW'(tail_sum - DepthP) : PtrW'(tail_sum);

  // saturating total
  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(size_inc);

  blwc_tab #(.DEPTH(ALPHABET_SIZE), .WIDTH(CntW)) u_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (restart),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (cnt_rd)
  );

  blwc_tab #(.DEPTH(ALPHABET_SIZE), .WIDTH(LIMIT_W)) u_lim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (1'b0),
    .we_i    (lim_we),
    .waddr_i (let_addr),
    .wdata_i (lim_q),
    .raddr_i (tab_raddr),
    .rdata_o (lim_rd)
  );

  blwc_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(LETTER_W)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (let_q),
    .raddr_i (oldest_q),
    .rdata_o (ram_rd)
  );

  // sequencer: next state and datapath controls
  always_comb begin
    state_d   = state_q;
    oldest_d  = oldest_q;
    size_d    = size_q;
    total_d   = total_q;
    sub_d     = sub_q;
    cap_d     = cap_q;
    evcap_d   = evcap_q;
    old_d     = old_q;
    old_ok_d  = old_ok_q;
    over_d    = over_q;
    restart   = 1'b0;
    cnt_we    = 1'b0;
    lim_we    = 1'b0;
    ram_we    = 1'b0;
    cnt_waddr = let_addr;
    cnt_wdata = cnt_inc;
    tab_raddr = let_addr;
    ram_waddr = tail;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sub_d = '0;
          cap_d = 1'b0;
          if (in_i.opcode == OP_RESTART) begin
            restart  = 1'b1;
            over_d   = '0;
            oldest_d = '0;
            size_d   = '0;
            total_d  = '0;
            state_d  = ST_DONE;
          end else if (32'(in_i.letter) >= ALPHABET_SIZE) begin
            state_d = ST_DONE;
          end else if (in_i.opcode == OP_LOAD) begin
            state_d = ST_LRD;
          end else if (in_i.opcode == OP_PUSH) begin
            state_d = ST_PRD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_LRD: begin
        state_d = ST_LWR;
      end
      ST_LWR: begin
        lim_we           = 1'b1;
        over_d[let_addr] = CmpW'(cnt_rd) > CmpW'(lim_q);
        state_d          = ST_DONE;
      end
      ST_PRD: begin
        state_d = ST_PINC;
      end
      ST_PINC: begin
        cnt_we           = 1'b1;
        cnt_wdata        = cnt_inc;
        over_d[let_addr] = CmpW'(cnt_inc) > CmpW'(lim_rd);
        state_d          = ST_CHK;
      end
      ST_CHK: begin
        if (|over_q) begin
          if (size_q != '0) begin
            evcap_d = 1'b0;
            state_d = ST_EV1;
          end else begin
            // new letter alone over its limit: drop it
            cnt_we           = 1'b1;
            cnt_wdata        = '0;
            over_d[let_addr] = 1'b0;
            state_d          = ST_DONE;
          end
        end else if (size_q == FullSz) begin
          evcap_d = 1'b1;
          cap_d   = 1'b1;
          state_d = ST_EV1;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_EV1: begin
        state_d = ST_EV2;
      end
      ST_EV2: begin
        old_d     = AW'(ram_rd);
        old_ok_d  = 32'(ram_rd) < ALPHABET_SIZE;
        tab_raddr = AW'(ram_rd);
        state_d   = ST_EV3;
      end
      ST_EV3: begin
        cnt_waddr = old_q;
        cnt_wdata = cnt_dec;
        if (old_ok_q && (cnt_rd != '0)) begin
          cnt_we        = 1'b1;
          over_d[old_q] = CmpW'(cnt_dec) > CmpW'(lim_rd);
        end
        oldest_d = (oldest_q == LastPtr) ? '0 : oldest_q + PtrW'(1);
        if (size_q != '0) begin
          size_d = size_q - SizeW'(1);
        end
        state_d = evcap_q ? ST_WR : ST_CHK;
      end
      ST_WR: begin
        ram_we  = 1'b1;
        size_d  = size_inc;
        sub_d   = size_inc;
        total_d = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      size_q   <= '0;
      total_q  <= '0;
      over_q   <= '0;
    end else begin
      oldest_q <= oldest_d;
      size_q   <= size_d;
      total_q  <= total_d;
      over_q   <= over_d;
    end
  end

  // item payload and per-item scratch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= blwc_op_e'(in_i.opcode);
      let_q <= in_i.letter;
      lim_q <= in_i.limit_value;
    end
    sub_q    <= sub_d;
    cap_q    <= cap_d;
    evcap_q  <= evcap_d;
    old_q    <= old_d;
    old_ok_q <= old_ok_d;
  end

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result beat payload, non-push items report no substrings and no cap
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_len_q   <= LEN_W'(size_q);
      res_sub_q   <= (op_q == OP_PUSH) ? LEN_W'(sub_q) : '0;
      res_total_q <= total_q;
      res_cap_q   <= (op_q == OP_PUSH) && cap_q;
    end
  end

  assign out_o.valid                  = out_vld_q;
  assign out_o.window_length          = res_len_q;
  assign out_o.substrings_ending_here = res_sub_q;
  assign out_o.running_total          = res_total_q;
  assign out_o.window_capped          = res_cap_q;

endmodule
